### src/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg: shared types and constants of the data segment decompressor
// Command codes, result kinds, controller/datapath command and status
// bundles, and the fixed pattern tables of the short pattern commands.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ABOVE_A5 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BELOW_A5 = 1'b1;

  localparam logic [7:0] LIT_BIAS  = 8'h7F;
  localparam logic [7:0] ZRUN_BIAS = 8'h3F;
  localparam logic [7:0] VRUN_BIAS = 8'h1E;
  localparam logic [7:0] FRUN_BIAS = 8'h0F;
  localparam logic [7:0] UNK_MIN   = 8'h05;
  localparam logic [7:0] BYTE_A9   = 8'hA9;
  localparam logic [7:0] BYTE_F0   = 8'hF0;
  localparam logic [7:0] BYTE_FF   = 8'hFF;

  localparam logic [2:0] PAT_CODE_1 = 3'd1;
  localparam logic [2:0] PAT_CODE_2 = 3'd2;
  localparam logic [2:0] PAT_CODE_3 = 3'd3;
  localparam logic [2:0] PAT_CODE_4 = 3'd4;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_ROUND_END = 3'd1,
    KIND_UNKNOWN   = 3'd2,
    KIND_ALL_DONE  = 3'd3,
    KIND_BAD_CFG   = 3'd4
  } kind_t;

  typedef enum logic [6:0] {
    PH_XREF   = 7'b0000001,
    PH_OFFSET = 7'b0000010,
    PH_CMD    = 7'b0000100,
    PH_LIT    = 7'b0001000,
    PH_RUNVAL = 7'b0010000,
    PH_PAT    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_EMIT = 2'b10
  } seq_t;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_PAT,
    CLS_UNK,
    CLS_FRUN,
    CLS_VRUN,
    CLS_ZRUN,
    CLS_LIT
  } cls_t;

  typedef enum logic [1:0] {HDR_HOLD, HDR_INC, HDR_CLR, HDR_SET1} hdr_op_t;
  typedef enum logic [1:0] {OFF_HOLD, OFF_SHIFT, OFF_CLR, OFF_LOAD} off_op_t;
  typedef enum logic [2:0] {REM_HOLD, REM_LOAD_LIT, REM_LOAD_RUN, REM_DEC, REM_CLR} rem_op_t;
  typedef enum logic [1:0] {PAT_HOLD, PAT_LOAD, PAT_INC} pat_op_t;

  typedef enum logic [3:0] {
    JOB_NONE,
    JOB_ZERO,
    JOB_FF,
    JOB_LIT,
    JOB_RUNV,
    JOB_PATPRE,
    JOB_PATD,
    JOB_END_OK,
    JOB_END_UNK,
    JOB_BAD
  } job_t;

  typedef struct packed {
    logic    load;
    hdr_op_t hdr_op;
    off_op_t off_op;
    logic    wp_clr;
    logic    round_inc;
    rem_op_t rem_op;
    pat_op_t pat_op;
    logic    start;
    job_t    job;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic cfg_bad;
    logic first;
    logic hdr_full;
    cls_t cls;
    logic lit_last;
    logic pat_valid;
    logic pat_done;
    logic last_round;
    logic slot_free;
    logic emit_last;
  } sts_t;

  function automatic logic [7:0] pat_prefix(input logic [2:0] code, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (code)
      PAT_CODE_1: b = (idx == 3'd4 || idx == 3'd5) ? BYTE_FF : 8'h00;
      PAT_CODE_2: b = (idx == 3'd4) ? BYTE_FF : 8'h00;
      PAT_CODE_3, PAT_CODE_4: begin
        if (idx == 3'd0) b = BYTE_A9;
        else if (idx == 3'd1) b = BYTE_F0;
        else b = 8'h00;
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] pat_prefix_len(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      PAT_CODE_1: n = 3'd6;
      PAT_CODE_2: n = 3'd5;
      PAT_CODE_3: n = 3'd4;
      PAT_CODE_4: n = 3'd3;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] pat_data_len(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      PAT_CODE_1: n = 3'd2;
      PAT_CODE_2: n = 3'd3;
      PAT_CODE_3: n = 3'd3;
      PAT_CODE_4: n = 3'd4;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] pat_zero_after(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      PAT_CODE_3: n = 3'd2;
      PAT_CODE_4: n = 3'd3;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### src/dsd_item_if.sv
// ----------------------------------------------------------------------------
// dsd_item_if: compressed byte channel
// Valid/ready channel carrying one compressed byte and its restart mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsd_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_byte;

  modport source (output valid, output in_byte, output first_byte, input ready);
  modport sink (input valid, input in_byte, input first_byte, output ready);
endinterface

`default_nettype wire

### src/dsd_result_if.sv
// ----------------------------------------------------------------------------
// dsd_result_if: decoded result channel
// Valid/ready channel carrying one decoded byte or one status event.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [16:0] out_address;
  logic [2:0]  kind;
  logic        out_of_range;
  logic        last;

  modport source (output valid, output out_byte, output out_address, output kind,
                  output out_of_range, output last, input ready);
  modport sink (input valid, input out_byte, input out_address, input kind,
                input out_of_range, input last, output ready);
endinterface

`default_nettype wire

### src/dsd_cfg_if.sv
// ----------------------------------------------------------------------------
// dsd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dsd_pkg::CFG_IDX_W-1:0]    index;
  logic [dsd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/dsd_ctrl.sv
// ----------------------------------------------------------------------------
// dsd_ctrl: decode controller
// Tracks the decode phase and sequences accept and result cycles; drives
// the datapath by command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output      logic          item_ready,
  input  wire dsd_pkg::sts_t sts,
  output      dsd_pkg::cmd_t cmd
);

  dsd_pkg::phase_t phase, phase_next, ph_eff;
  dsd_pkg::seq_t   seq, seq_next;

  always_comb begin
    cmd        = '0;
    phase_next = phase;
    seq_next   = seq;
    ph_eff     = sts.first ? dsd_pkg::PH_XREF : phase;
    item_ready = (seq == dsd_pkg::SEQ_IDLE);
    case (seq)
      dsd_pkg::SEQ_IDLE: begin
        if (item_valid) begin
          if (sts.cfg_bad) begin
            cmd.start = 1'b1;
            cmd.job   = dsd_pkg::JOB_BAD;
          end else begin
            cmd.load   = 1'b1;
            phase_next = ph_eff;
            case (ph_eff)
              dsd_pkg::PH_XREF: begin
                if (sts.hdr_full) begin
                  phase_next = dsd_pkg::PH_OFFSET;
                  cmd.hdr_op = dsd_pkg::HDR_CLR;
                  cmd.off_op = dsd_pkg::OFF_CLR;
                end else begin
                  cmd.hdr_op = dsd_pkg::HDR_INC;
                end
              end
              dsd_pkg::PH_OFFSET: begin
                cmd.off_op = dsd_pkg::OFF_SHIFT;
                if (sts.hdr_full) begin
                  phase_next = dsd_pkg::PH_CMD;
                  cmd.hdr_op = dsd_pkg::HDR_CLR;
                  cmd.wp_clr = 1'b1;
                end else begin
                  cmd.hdr_op = dsd_pkg::HDR_INC;
                end
              end
              dsd_pkg::PH_CMD: begin
                case (sts.cls)
                  dsd_pkg::CLS_LIT: begin
                    cmd.rem_op = dsd_pkg::REM_LOAD_LIT;
                    phase_next = dsd_pkg::PH_LIT;
                  end
                  dsd_pkg::CLS_ZRUN: begin
                    cmd.start = 1'b1;
                    cmd.job   = dsd_pkg::JOB_ZERO;
                  end
                  dsd_pkg::CLS_VRUN: begin
                    cmd.rem_op = dsd_pkg::REM_LOAD_RUN;
                    phase_next = dsd_pkg::PH_RUNVAL;
                  end
                  dsd_pkg::CLS_FRUN: begin
                    cmd.start = 1'b1;
                    cmd.job   = dsd_pkg::JOB_FF;
                  end
                  dsd_pkg::CLS_UNK: begin
                    // the code byte doubles as the first offset byte of the next round
                    cmd.start     = 1'b1;
                    cmd.job       = dsd_pkg::JOB_END_UNK;
                    cmd.round_inc = 1'b1;
                    if (sts.last_round) begin
                      phase_next = dsd_pkg::PH_DONE;
                    end else begin
                      phase_next = dsd_pkg::PH_OFFSET;
                      cmd.hdr_op = dsd_pkg::HDR_SET1;
                      cmd.off_op = dsd_pkg::OFF_LOAD;
                    end
                  end
                  dsd_pkg::CLS_PAT: begin
                    cmd.start  = 1'b1;
                    cmd.job    = dsd_pkg::JOB_PATPRE;
                    cmd.pat_op = dsd_pkg::PAT_LOAD;
                    phase_next = dsd_pkg::PH_PAT;
                  end
                  default: begin
                    cmd.start     = 1'b1;
                    cmd.job       = dsd_pkg::JOB_END_OK;
                    cmd.round_inc = 1'b1;
                    if (sts.last_round) begin
                      phase_next = dsd_pkg::PH_DONE;
                    end else begin
                      phase_next = dsd_pkg::PH_OFFSET;
                      cmd.hdr_op = dsd_pkg::HDR_CLR;
                      cmd.off_op = dsd_pkg::OFF_CLR;
                    end
                  end
                endcase
              end
              dsd_pkg::PH_LIT: begin
                cmd.start  = 1'b1;
                cmd.job    = dsd_pkg::JOB_LIT;
                cmd.rem_op = dsd_pkg::REM_DEC;
                if (sts.lit_last) phase_next = dsd_pkg::PH_CMD;
              end
              dsd_pkg::PH_RUNVAL: begin
                cmd.start  = 1'b1;
                cmd.job    = dsd_pkg::JOB_RUNV;
                cmd.rem_op = dsd_pkg::REM_CLR;
                phase_next = dsd_pkg::PH_CMD;
              end
              dsd_pkg::PH_PAT: begin
                if (!sts.pat_valid) begin
                  phase_next = dsd_pkg::PH_CMD;
                end else begin
                  cmd.start  = 1'b1;
                  cmd.job    = dsd_pkg::JOB_PATD;
                  cmd.pat_op = dsd_pkg::PAT_INC;
                  if (sts.pat_done) phase_next = dsd_pkg::PH_CMD;
                end
              end
              default: ;
            endcase
          end
        end
      end
      dsd_pkg::SEQ_EMIT: begin
        cmd.emit = sts.slot_free;
        if (sts.slot_free && sts.emit_last) seq_next = dsd_pkg::SEQ_IDLE;
      end
      default: seq_next = dsd_pkg::SEQ_IDLE;
    endcase
    if (cmd.start) seq_next = dsd_pkg::SEQ_EMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dsd_pkg::PH_XREF;
      seq   <= dsd_pkg::SEQ_IDLE;
    end else begin
      phase <= phase_next;
      seq   <= seq_next;
    end
  end

endmodule

`default_nettype wire

### src/dsd_datapath.sv
// ----------------------------------------------------------------------------
// dsd_datapath: decode registers, result generator and result register
// Holds sizes, offset, position and counters; builds one result per emit
// command and keeps it in the output register until transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_datapath #(
  parameter int ROUNDS = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dsd_pkg::cmd_t                    cmd,
  output      dsd_pkg::sts_t                    sts,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             first_byte,
  input  wire logic                             cfg_valid,
  input  wire logic [dsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [7:0]                       out_byte,
  output      logic [16:0]                      out_address,
  output      logic [2:0]                       out_kind,
  output      logic                             out_of_range,
  output      logic                             out_last
);

  logic [15:0] above, below;
  logic [1:0]  hc, hc_eff, hc_next;
  logic [1:0]  round, round_eff, round_next;
  logic [31:0] off, off_eff, off_next;
  logic [32:0] wp;
  logic [7:0]  rem, rem_eff, rem_next;
  logic [2:0]  pcode, pcode_next, step, step_eff, step_next, step_inc;

  dsd_pkg::job_t job_q;
  logic [6:0]    cnt_q, cnt_start;
  logic [5:0]    idx_q;
  logic [7:0]    val_q;

  logic [7:0]    zrun_cnt, frun_cnt;
  logic [2:0]    round_inc3;
  logic          pat_zero;

  logic          res_data;
  logic [7:0]    res_byte;
  dsd_pkg::kind_t res_kind;
  logic [34:0]   addr;
  logic [16:0]   total;
  logic          res_oor;

  // effective state: a restart byte sees cleared decode state
  always_comb begin
    hc_eff     = first_byte ? 2'd0 : hc;
    round_eff  = first_byte ? 2'd0 : round;
    off_eff    = first_byte ? 32'd0 : off;
    rem_eff    = first_byte ? 8'd0 : rem;
    step_eff   = first_byte ? 3'd0 : step;
    step_inc   = step_eff + 3'd1;
    round_inc3 = {1'b0, round_eff} + 3'd1;
    pat_zero   = (step_inc == dsd_pkg::pat_zero_after(pcode));
    zrun_cnt   = in_byte - dsd_pkg::ZRUN_BIAS;
    frun_cnt   = in_byte - dsd_pkg::FRUN_BIAS;
  end

  always_comb begin
    sts.cfg_bad    = (above == 16'd0) || (below == 16'd0);
    sts.first      = first_byte;
    sts.hdr_full   = (hc_eff == 2'd3);
    if (in_byte[7]) sts.cls = dsd_pkg::CLS_LIT;
    else if (in_byte[6]) sts.cls = dsd_pkg::CLS_ZRUN;
    else if (in_byte[5]) sts.cls = dsd_pkg::CLS_VRUN;
    else if (in_byte[4]) sts.cls = dsd_pkg::CLS_FRUN;
    else if (in_byte >= dsd_pkg::UNK_MIN) sts.cls = dsd_pkg::CLS_UNK;
    else if (in_byte != 8'd0) sts.cls = dsd_pkg::CLS_PAT;
    else sts.cls = dsd_pkg::CLS_END;
    sts.lit_last   = (rem_eff <= 8'd1);
    sts.pat_valid  = (pcode >= dsd_pkg::PAT_CODE_1) && (pcode <= dsd_pkg::PAT_CODE_4);
    sts.pat_done   = (step_inc >= dsd_pkg::pat_data_len(pcode));
    sts.last_round = (round_inc3[1:0] == 2'd0) ? (3'd4 >= 3'(ROUNDS))
                                               : (round_inc3 >= 3'(ROUNDS));
    sts.slot_free  = !out_valid || out_ready;
    sts.emit_last  = (({1'b0, idx_q} + 7'd1) == cnt_q);
  end

  // next values of the decode registers
  always_comb begin
    case (cmd.hdr_op)
      dsd_pkg::HDR_INC:  hc_next = hc_eff + 2'd1;
      dsd_pkg::HDR_CLR:  hc_next = 2'd0;
      dsd_pkg::HDR_SET1: hc_next = 2'd1;
      default:           hc_next = hc_eff;
    endcase
    case (cmd.off_op)
      dsd_pkg::OFF_SHIFT: off_next = {off_eff[23:0], in_byte};
      dsd_pkg::OFF_CLR:   off_next = 32'd0;
      dsd_pkg::OFF_LOAD:  off_next = {24'd0, in_byte};
      default:            off_next = off_eff;
    endcase
    case (cmd.rem_op)
      dsd_pkg::REM_LOAD_LIT: rem_next = in_byte - dsd_pkg::LIT_BIAS;
      dsd_pkg::REM_LOAD_RUN: rem_next = in_byte - dsd_pkg::VRUN_BIAS;
      dsd_pkg::REM_DEC:      rem_next = (rem_eff != 8'd0) ? rem_eff - 8'd1 : 8'd0;
      dsd_pkg::REM_CLR:      rem_next = 8'd0;
      default:               rem_next = rem_eff;
    endcase
    case (cmd.pat_op)
      dsd_pkg::PAT_LOAD: begin
        pcode_next = in_byte[2:0];
        step_next  = 3'd0;
      end
      dsd_pkg::PAT_INC: begin
        pcode_next = pcode;
        step_next  = step_inc;
      end
      default: begin
        pcode_next = first_byte ? 3'd0 : pcode;
        step_next  = step_eff;
      end
    endcase
    round_next = cmd.round_inc ? round_inc3[1:0] : round_eff;
  end

  // result count of a job, known when it starts
  always_comb begin
    case (cmd.job)
      dsd_pkg::JOB_ZERO:    cnt_start = zrun_cnt[6:0];
      dsd_pkg::JOB_FF:      cnt_start = frun_cnt[6:0];
      dsd_pkg::JOB_RUNV:    cnt_start = rem_eff[6:0];
      dsd_pkg::JOB_PATPRE:  cnt_start = {4'd0, dsd_pkg::pat_prefix_len(in_byte[2:0])};
      dsd_pkg::JOB_PATD:    cnt_start = pat_zero ? 7'd2 : 7'd1;
      dsd_pkg::JOB_END_OK,
      dsd_pkg::JOB_END_UNK: cnt_start = sts.last_round ? 7'd2 : 7'd1;
      default:              cnt_start = 7'd1;
    endcase
  end

  // one result from the running job
  always_comb begin
    res_data = 1'b1;
    res_byte = 8'd0;
    res_kind = dsd_pkg::KIND_DATA;
    case (job_q)
      dsd_pkg::JOB_ZERO:   res_byte = 8'd0;
      dsd_pkg::JOB_FF:     res_byte = dsd_pkg::BYTE_FF;
      dsd_pkg::JOB_LIT,
      dsd_pkg::JOB_RUNV:   res_byte = val_q;
      dsd_pkg::JOB_PATPRE: res_byte = dsd_pkg::pat_prefix(val_q[2:0], idx_q[2:0]);
      dsd_pkg::JOB_PATD:   res_byte = (idx_q == 6'd0) ? val_q : 8'd0;
      dsd_pkg::JOB_END_OK: begin
        res_data = 1'b0;
        res_kind = (idx_q == 6'd0) ? dsd_pkg::KIND_ROUND_END : dsd_pkg::KIND_ALL_DONE;
      end
      dsd_pkg::JOB_END_UNK: begin
        res_data = 1'b0;
        res_kind = (idx_q == 6'd0) ? dsd_pkg::KIND_UNKNOWN : dsd_pkg::KIND_ALL_DONE;
      end
      default: begin
        res_data = 1'b0;
        res_kind = dsd_pkg::KIND_BAD_CFG;
      end
    endcase
    addr    = {19'd0, below} + {{3{off[31]}}, off} + {2'd0, wp};
    total   = {1'b0, above} + {1'b0, below};
    res_oor = addr[34] || (addr[33:0] >= {17'd0, total});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above     <= 16'd0;
      below     <= 16'd0;
      hc        <= 2'd0;
      round     <= 2'd0;
      off       <= 32'd0;
      wp        <= 33'd0;
      rem       <= 8'd0;
      pcode     <= 3'd0;
      step      <= 3'd0;
      job_q     <= dsd_pkg::JOB_NONE;
      cnt_q     <= 7'd0;
      idx_q     <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          dsd_pkg::REG_ABOVE_A5: above <= cfg_data;
          dsd_pkg::REG_BELOW_A5: below <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        hc    <= hc_next;
        round <= round_next;
        off   <= off_next;
        rem   <= rem_next;
        pcode <= pcode_next;
        step  <= step_next;
      end
      if (cmd.load && (first_byte || cmd.wp_clr)) begin
        wp <= 33'd0;
      end else if (cmd.emit && res_data) begin
        wp <= wp + 33'd1;
      end
      if (cmd.start) begin
        job_q <= cmd.job;
        cnt_q <= cnt_start;
        idx_q <= 6'd0;
      end else if (cmd.emit) begin
        idx_q <= idx_q + 6'd1;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) val_q <= in_byte;
    if (cmd.emit) begin
      out_byte     <= res_byte;
      out_address  <= (res_data && !res_oor) ? addr[16:0] : 17'd0;
      out_kind     <= res_kind;
      out_of_range <= res_data && res_oor;
      out_last     <= sts.emit_last;
    end
  end

endmodule

`default_nettype wire

### src/data_segment_decompressor.sv
// ----------------------------------------------------------------------------
// data_segment_decompressor: data resource decompressor, byte in, bytes out
// Controller plus datapath; one compressed byte per transfer, one decoded
// byte or status event per result transfer.
// ----------------------------------------------------------------------------
// Feed the compressed resource one byte per item transfer; set first_byte on
// its first byte to restart decoding. The block skips the 4-byte
// cross-reference word, then decodes ROUNDS rounds, each a big-endian signed
// 32-bit offset followed by command bytes. Every decoded byte comes out with
// its buffer address below_a5_size + offset + position (out_address is 0 and
// out_of_range is 1 when that lies outside the buffer of
// above_a5_size + below_a5_size bytes), and round ends, unknown codes, the
// end of all rounds and a zero size register come out as status results
// (kind 1 to 4). The last result caused by a byte carries last. A byte is
// taken, then its results (at most 64, for a 64-byte zero run) leave one by
// one through the single result register, each waiting until it is free,
// and no new byte is taken meanwhile; bytes with no result are taken every
// cycle. A new byte is accepted while the last result of the previous one
// still waits to be transferred. Write the size registers only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module data_segment_decompressor #(
  parameter int ROUNDS = 3
) (
  input wire logic   clk,
  input wire logic   rst,
  dsd_item_if.sink   item,
  dsd_result_if.source result,
  dsd_cfg_if.sink    cfg
);

  dsd_pkg::cmd_t cmd;
  dsd_pkg::sts_t sts;

  // size registers take a write in any cycle
  assign cfg.ready = 1'b1;

  dsd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dsd_datapath #(
    .ROUNDS (ROUNDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_byte      (item.in_byte),
    .first_byte   (item.first_byte),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_byte     (result.out_byte),
    .out_address  (result.out_address),
    .out_kind     (result.kind),
    .out_of_range (result.out_of_range),
    .out_last     (result.last)
  );

endmodule

`default_nettype wire
